/* rtl/perfect_mixing_mill_discharge_defines.svh */
// assertion macros for the mill discharge block
`ifndef PERFECT_MIXING_MILL_DISCHARGE_DEFINES_SVH
`define PERFECT_MIXING_MILL_DISCHARGE_DEFINES_SVH

// same-cycle implication
`define PMMD_ASSERT_IMP(lbl, clk, rstn, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (con)) else $error(msg);

// next-cycle implication
`define PMMD_ASSERT_NXT(lbl, clk, rstn, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (con)) else $error(msg);

`endif

/* rtl/pmmd_pkg.sv */
// shared constants for the mill discharge block
package pmmd_pkg;

  localparam int MAX_CLASSES = 32;
  localparam int IDX_W       = $clog2(MAX_CLASSES);
  localparam int NUM_W       = 64;
  localparam int DEN_W       = 40;
  localparam int QUO_W       = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MILL_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MILL_DIAMETER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MILL_LENGTH   = 2'd2;

endpackage

/* rtl/pmmd_if.sv */
// beat interfaces for class items and discharge results
interface pmmd_in_if;
  logic        valid;
  logic        ready;
  logic        first_class;
  logic        last_class;
  logic [31:0] feed_mass;
  logic [31:0] breakage_rate;
  logic [15:0] appearance;
  logic [31:0] feed_volume;
  modport source (output valid, first_class, last_class, feed_mass, breakage_rate,
                  appearance, feed_volume, input ready);
  modport sink (input valid, first_class, last_class, feed_mass, breakage_rate,
                appearance, feed_volume, output ready);
endinterface

interface pmmd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] discharge_mass;
  logic [4:0]  class_index;
  logic        last;
  modport source (output valid, discharge_mass, class_index, last, input ready);
  modport sink (input valid, discharge_mass, class_index, last, output ready);
endinterface

/* rtl/perfect_mixing_mill_discharge.sv */
// undersize class goes straight to its result; other classes run ratio division, a MAC
// over earlier classes, discharge division and store; a first class adds the residence scale
// one shared 32x32 multiplier and one bit-serial divider serve all products and quotients
// one item at a time; the result register lets the next item in while a result waits
// reset clears control, counter, balance and scale; both class stores start undefined
// top level: perfect-mixing mill discharge, one size class per beat
module perfect_mixing_mill_discharge
  import pmmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pmmd_in_if.sink               in_i,
  pmmd_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_DIVS    = 4'd1;
  localparam logic [3:0] ST_DIVW    = 4'd2;
  localparam logic [3:0] ST_MUL_DD  = 4'd3;
  localparam logic [3:0] ST_MUL_DEN = 4'd4;
  localparam logic [3:0] ST_MAC_RD  = 4'd5;
  localparam logic [3:0] ST_MAC_MUL = 4'd6;
  localparam logic [3:0] ST_MAC_ACC = 4'd7;
  localparam logic [3:0] ST_MUL_RD  = 4'd8;
  localparam logic [3:0] ST_FIN     = 4'd9;

  localparam logic [2:0] OP_Q = 3'd0;
  localparam logic [2:0] OP_S = 3'd1;
  localparam logic [2:0] OP_R = 3'd2;
  localparam logic [2:0] OP_P = 3'd3;
  localparam logic [2:0] OP_W = 3'd4;

  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_CLASSES - 1);

  logic [3:0]       state_q, state_d;
  logic [2:0]       op_q, op_d;
  logic [7:0]       cnt_cfg_q;
  logic [23:0]      dia_q, len_q;
  logic [IDX_W-1:0] idx_q, cnt_q, j_q;
  logic [39:0]      rem_q;
  logic [31:0]      scale_q;
  logic             last_q;
  logic [31:0]      feed_q, rate_q, vol_q, q_q, ratio_q, dis_q;
  logic [63:0]      acc_q, prod_q;
  logic [15:0]      app_rd_q;
  logic [31:0]      rd_rd_q;
  logic             out_valid_q;
  logic [31:0]      out_data_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_last_q;

  logic [15:0]      app_mem [MAX_CLASSES];
  logic [31:0]      rd_mem  [MAX_CLASSES];

  logic             in_acc, out_free;
  logic [IDX_W-1:0] idx_in;
  logic [39:0]      rem_base;
  logic [31:0]      mul_a, mul_b;
  logic             div_start, div_done;
  logic [63:0]      div_num;
  logic [39:0]      div_den;
  logic [31:0]      div_quo;
  logic [31:0]      last_dis;

  function automatic logic [39:0] sat40(input logic [40:0] s);
    if (s[40] != s[39]) begin
      return s[40] ? 40'h80_0000_0000 : 40'h7F_FFFF_FFFF;
    end
    return s[39:0];
  endfunction

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign idx_in     = in_i.first_class ? '0 : cnt_q;
  assign rem_base   = in_i.first_class ? '0 : rem_q;
  assign div_start  = (state_q == ST_DIVS);

  assign last_dis = rem_q[39] ? '0 : ((rem_q[39:32] != '0) ? '1 : rem_q[31:0]);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_cfg_q <= 8'd1;
      dia_q     <= 24'd65536;
      len_q     <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MILL_COUNT:    cnt_cfg_q <= cfg_data_i[7:0];
        CFG_MILL_DIAMETER: dia_q     <= cfg_data_i;
        CFG_MILL_LENGTH:   len_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // divider operand select
  always_comb begin
    case (op_q)
      OP_Q: begin
        div_num = {32'd0, vol_q};
        div_den = (cnt_cfg_q == '0) ? 40'd1 : {32'd0, cnt_cfg_q};
      end
      OP_S: begin
        div_num = {14'd0, q_q, 18'd0};
        div_den = prod_q[55:16];
      end
      OP_R: begin
        div_num = {16'd0, rate_q, 16'd0};
        div_den = {8'd0, scale_q};
      end
      OP_P: begin
        div_num = acc_q + {16'd0, feed_q, 16'd0};
        div_den = {8'd0, ratio_q} + 40'd65536;
      end
      default: begin
        div_num = prod_q;
        div_den = {8'd0, scale_q};
      end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (state_q)
      ST_MUL_DD: begin
        mul_a = {8'd0, dia_q};
        mul_b = {8'd0, dia_q};
      end
      ST_MUL_DEN: begin
        mul_a = prod_q[47:16];
        mul_b = {8'd0, len_q};
      end
      ST_MAC_MUL: begin
        mul_a = {16'd0, app_rd_q};
        mul_b = rd_rd_q;
      end
      default: begin
        mul_a = rate_q;
        mul_b = dis_q;
      end
    endcase
  end

  pmmd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.first_class) begin
            op_d    = OP_Q;
            state_d = ST_DIVS;
          end else if (in_i.last_class) begin
            state_d = ST_FIN;
          end else begin
            op_d    = OP_R;
            state_d = ST_DIVS;
          end
        end
      end
      ST_DIVS: state_d = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          case (op_q)
            OP_Q: state_d = ST_MUL_DD;
            OP_S: begin
              if (last_q) begin
                state_d = ST_FIN;
              end else begin
                op_d    = OP_R;
                state_d = ST_DIVS;
              end
            end
            OP_R: begin
              if (idx_q == '0) begin
                op_d    = OP_P;
                state_d = ST_DIVS;
              end else begin
                state_d = ST_MAC_RD;
              end
            end
            OP_P: state_d = ST_MUL_RD;
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_MUL_DD:  state_d = ST_MUL_DEN;
      ST_MUL_DEN: begin
        op_d    = OP_S;
        state_d = ST_DIVS;
      end
      ST_MAC_RD:  state_d = ST_MAC_MUL;
      ST_MAC_MUL: state_d = ST_MAC_ACC;
      ST_MAC_ACC: begin
        if (j_q + 1'b1 == idx_q) begin
          op_d    = OP_P;
          state_d = ST_DIVS;
        end else begin
          state_d = ST_MAC_RD;
        end
      end
      ST_MUL_RD: begin
        op_d    = OP_W;
        state_d = ST_DIVS;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_Q;
      cnt_q       <= '0;
      rem_q       <= '0;
      scale_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      if (in_acc) begin
        rem_q <= sat40({rem_base[39], rem_base} + {9'd0, in_i.feed_mass});
      end
      if (state_q == ST_DIVW && div_done) begin
        if (op_q == OP_S) begin
          scale_q <= div_quo;
        end
        if (op_q == OP_W) begin
          rem_q <= sat40({rem_q[39], rem_q} - {9'd0, dis_q});
        end
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          cnt_q <= '0;
          rem_q <= '0;
        end else begin
          cnt_q <= (idx_q < IDX_TOP) ? idx_q + 1'b1 : idx_q;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath and result registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_q  <= in_i.last_class;
      feed_q  <= in_i.feed_mass;
      rate_q  <= in_i.breakage_rate;
      vol_q   <= in_i.feed_volume;
      idx_q   <= idx_in;
    end
    if (state_q == ST_MUL_DD || state_q == ST_MUL_DEN || state_q == ST_MAC_MUL ||
        state_q == ST_MUL_RD) begin
      prod_q <= 64'(mul_a) * 64'(mul_b);
    end
    if (state_q == ST_DIVW && div_done) begin
      case (op_q)
        OP_Q: q_q <= div_quo;
        OP_R: begin
          ratio_q <= div_quo;
          acc_q   <= '0;
          j_q     <= '0;
        end
        OP_P: dis_q <= div_quo;
        default: ;
      endcase
    end
    if (state_q == ST_MAC_ACC) begin
      acc_q <= acc_q + prod_q;
      j_q   <= j_q + 1'b1;
    end
    if (state_q == ST_FIN && out_free) begin
      out_data_q <= last_q ? last_dis : dis_q;
      out_idx_q  <= idx_q;
      out_last_q <= last_q;
    end
  end

  // class stores
  always_ff @(posedge clk_i) begin
    if (in_acc && !in_i.last_class) begin
      app_mem[idx_in] <= in_i.appearance;
    end
    if (state_q == ST_DIVW && div_done && op_q == OP_W) begin
      rd_mem[idx_q] <= div_quo;
    end
    app_rd_q <= app_mem[idx_q - j_q];
    rd_rd_q  <= rd_mem[j_q];
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.discharge_mass = out_data_q;
  assign out_o.class_index    = 5'(out_idx_q);
  assign out_o.last           = out_last_q;

endmodule

/* rtl/pmmd_div.sv */
// saturating restoring divider, one quotient bit per cycle
module pmmd_div
  import pmmd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0] sh_q, quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, sh_q[QUO_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else if ({{(DEN_W-QUO_W){1'b0}}, num_i[NUM_W-1:QUO_W]} >= den_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(QUO_W);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= {{(DEN_W-QUO_W){1'b0}}, num_i[NUM_W-1:QUO_W]};
      sh_q  <= num_i[QUO_W-1:0];
      if (den_i == '0) begin
        quo_q <= (num_i != '0) ? '1 : '0;
      end else begin
        quo_q <= '1;
      end
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[DEN_W-1:0];
      end
      sh_q  <= {sh_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/pmmd_checker.sv */
// port-level assertions for the mill discharge block
`include "perfect_mixing_mill_discharge_defines.svh"

module pmmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i
);

  `PMMD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result beat dropped while stalled")
  `PMMD_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input taken while an item is in work")
  `PMMD_ASSERT_IMP(a_free_on_result, clk_i, rst_ni, $rose(out_valid_i), in_ready_i, "not ready for the next item after a result")

endmodule

bind perfect_mixing_mill_discharge pmmd_checker u_pmmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

/* tb/tb_top.sv */
// self-checking testbench for the perfect-mixing mill discharge block
module tb_top;
  import pmmd_pkg::*;

  typedef struct {
    bit        first;
    bit        last;
    bit [31:0] feed;
    bit [31:0] rate;
    bit [15:0] app;
    bit [31:0] vol;
  } class_item_t;

  typedef struct {
    bit [31:0] mass;
    bit [4:0]  cls;
    bit        last;
  } discharge_t;

  localparam longint unsigned M32 = 64'hFFFF_FFFF;
  localparam longint BAL_MAX = 64'sd549755813887;
  localparam longint BAL_MIN = -64'sd549755813888;

  class discharge_board;
    bit [7:0]        n_mills  = 1;
    bit [23:0]       diameter = 24'd65536;
    bit [23:0]       length   = 24'd65536;
    bit [15:0]       app_mem[MAX_CLASSES];
    bit [31:0]       rd_mem[MAX_CLASSES];
    int              counter;
    longint          balance;
    bit [31:0]       scale;
    discharge_t      expected_discharge[$];
    int              errors;
    int              checked;

    function longint unsigned qdiv(longint unsigned n, longint unsigned d);
      if (d == 0) return (n != 0) ? M32 : 0;
      return (n / d > M32) ? M32 : n / d;
    endfunction

    function longint clamp_bal(longint v);
      if (v > BAL_MAX) return BAL_MAX;
      if (v < BAL_MIN) return BAL_MIN;
      return v;
    endfunction

    function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MILL_COUNT:    n_mills = val[7:0];
        CFG_MILL_DIAMETER: diameter = val;
        CFG_MILL_LENGTH:   length = val;
        default: ;
      endcase
    endfunction

    function void note_class(class_item_t it);
      longint unsigned q, dd, den, ratio, acc, dis, d;
      int idx;
      discharge_t r;
      if (it.first) begin
        counter = 0;
        balance = 0;
        q   = 64'(it.vol) / ((n_mills == 0) ? 64'd1 : 64'(n_mills));
        dd  = (64'(diameter) * 64'(diameter)) >> 16;
        den = (dd * 64'(length)) >> 16;
        scale = 32'(qdiv((4 * q) << 16, den));
      end
      if (counter >= MAX_CLASSES) counter = MAX_CLASSES - 1;
      idx = counter;
      balance = clamp_bal(balance + longint'(64'(it.feed)));
      r.cls = idx[4:0];
      if (it.last) begin
        if (balance < 0) d = 0;
        else if (balance > longint'(M32)) d = M32;
        else d = balance;
        r.mass = d[31:0];
        r.last = 1;
        counter = 0;
        balance = 0;
      end else begin
        app_mem[idx] = it.app;
        ratio = qdiv(64'(it.rate) << 16, 64'(scale));
        acc = 0;
        for (int j = 0; j < idx; j++) acc += 64'(app_mem[idx-j]) * 64'(rd_mem[j]);
        dis = qdiv(acc + (64'(it.feed) << 16), ratio + 64'd65536);
        rd_mem[idx] = 32'(qdiv(64'(it.rate) * dis, 64'(scale)));
        balance = clamp_bal(balance - longint'(dis));
        r.mass = dis[31:0];
        r.last = 0;
        if (counter < MAX_CLASSES - 1) counter++;
      end
      expected_discharge.push_back(r);
    endfunction

    function void check_beat(bit [31:0] mass, bit [4:0] cls, bit last);
      discharge_t e;
      checked++;
      if (expected_discharge.size() == 0) begin
        $error("unexpected discharge beat: mass %h class %0d", mass, cls);
        errors++;
        return;
      end
      e = expected_discharge.pop_front();
      if (mass !== e.mass) begin
        $error("discharge_mass: expected %h, got %h", e.mass, mass);
        errors++;
      end
      if (cls !== e.cls) begin
        $error("class_index: expected %0d, got %0d", e.cls, cls);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  pmmd_in_if  in_bus();
  pmmd_out_if out_bus();

  perfect_mixing_mill_discharge uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  discharge_board sb = new();
  int idle_pct;
  int stall_pct;
  int sent;
  int quiet_cycles;
  int dists;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_bus.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.check_beat(out_bus.discharge_mass, out_bus.class_index, out_bus.last);
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || !rst_ni)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(32'h0008_0000);
    endcase
  endfunction

  function automatic class_item_t make_class(bit first, bit last);
    class_item_t it;
    it.first = first;
    it.last  = last;
    it.feed  = pick_word();
    it.rate  = pick_word();
    it.app   = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(16'h2000));
    it.vol   = pick_word();
    return it;
  endfunction

  task automatic send_class(class_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_bus.valid = 0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_bus.first_class   = it.first;
    in_bus.last_class    = it.last;
    in_bus.feed_mass     = it.feed;
    in_bus.breakage_rate = it.rate;
    in_bus.appearance    = it.app;
    in_bus.feed_volume   = it.vol;
    in_bus.valid         = 1;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_class(it);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_bus.valid = 0;
    while (sb.expected_discharge.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
    cfg_we   = 1;
    cfg_idx  = idx;
    cfg_data = val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we = 0;
  endtask

  task automatic set_mill(bit [7:0] n, bit [23:0] d, bit [23:0] l);
    drain();
    repeat (300) @(negedge clk_i);
    write_reg(CFG_MILL_COUNT, 24'(n));
    write_reg(CFG_MILL_DIAMETER, d);
    write_reg(CFG_MILL_LENGTH, l);
  endtask

  task automatic send_dist(int len, bit with_first);
    for (int k = 0; k < len; k++)
      send_class(make_class(with_first && k == 0, k == len - 1));
    dists++;
  endtask

  task automatic random_block(int n_items);
    int target;
    target = sent + n_items;
    while (sent < target) begin
      case ($urandom_range(19))
        0: send_class(make_class(1'($urandom_range(1)), 1'($urandom_range(1))));
        1: send_dist($urandom_range(1, 4), 0);
        2: send_dist($urandom_range(33, 36), 1);
        default: send_dist($urandom_range(1, 10), 1);
      endcase
    end
  endtask

  initial begin
    in_bus.valid = 0;
    in_bus.first_class = 0;
    in_bus.last_class = 0;
    in_bus.feed_mass = 0;
    in_bus.breakage_rate = 0;
    in_bus.appearance = 0;
    in_bus.feed_volume = 0;
    out_bus.ready = 0;
    cfg_we = 0;
    cfg_idx = CFG_MILL_COUNT;
    cfg_data = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_ni = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: one-class distribution, extremes, missing first, negative balance
    send_class('{1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF});
    send_class('{1, 1, 32'd0, 32'd0, 16'd0, 32'd0});
    send_class('{1, 0, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 32'h0001_0000});
    send_class('{0, 0, 32'h0001_0000, 32'hFFFF_FFFF, 16'hFFFF, 32'd0});
    send_class('{0, 0, 32'h0010_0000, 32'h0001_0000, 16'h8000, 32'd0});
    send_class('{0, 1, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd0});
    send_class('{1, 0, 32'h0004_0000, 32'h0002_0000, 16'h0000, 32'd0});
    send_class('{0, 0, 32'h0000_0000, 32'h0003_0000, 16'hFFFF, 32'd0});
    send_class('{0, 1, 32'd0, 32'd0, 16'd0, 32'd0});
    send_class('{0, 0, 32'h0002_0000, 32'h0001_0000, 16'h4000, 32'hFFFF_FFFF});
    send_class('{0, 1, 32'h0000_0001, 32'd0, 16'd0, 32'd0});
    send_class('{1, 0, 32'h0001_0000, 32'h8000_0000, 16'h1234, 32'h0000_0001});
    send_class('{0, 0, 32'h7FFF_FFFF, 32'h0000_0001, 16'hFFFF, 32'd0});
    send_class('{0, 1, 32'h0000_0000, 32'h0000_0000, 16'd0, 32'd0});

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      case (ph)
        0: set_mill(8'd255, 24'd1, 24'd1);
        1: set_mill(8'd0, 24'hFF_FFFF, 24'hFF_FFFF);
        2: set_mill(8'd1, 24'd65536, 24'd65536);
        default: set_mill(8'd3, 24'h03_0000, 24'h02_8000);
      endcase
      random_block(180);
      drain();
      set_mill(8'($urandom_range(1, 255)), 24'($urandom_range(24'hFF_FFFF, 1)),
               24'($urandom_range(24'hFF_FFFF, 1)));
      random_block(90);
      drain();
      random_block(130);
    end

    drain();
    repeat (400) @(posedge clk_i);
    $display("covered %0d class beats in %0d distributions, %0d discharges checked,",
             sent, dists, sb.checked);
    $display("across four idle/stall mixes and nine mill settings");
    if (sb.errors == 0 && sb.expected_discharge.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
